FILE: rtl/lbb_pkg.sv
// lbb_pkg: types and constants for the led breathing/blink controller
// transaction payload structs, mode and register codes, ramp constants
// no dependencies

package lbb_pkg;

	localparam int STEP_PERCENT = 2;

	localparam logic [6:0] LEVEL_MAX = 7'd100;
	localparam logic [6:0] LEVEL_DIV = 7'd33;

	localparam logic [9:0]  RST_STEP_MIN    = 10'd10;
	localparam logic [11:0] RST_ON_HOLD     = 12'd600;
	localparam logic [11:0] RST_OFF_HOLD    = 12'd2600;
	localparam logic [11:0] RST_BLINK_SHORT = 12'd200;
	localparam logic [11:0] RST_BLINK_LONG  = 12'd2000;

	localparam logic OP_SET_MODE = 1'b0;
	localparam logic OP_TICK     = 1'b1;

	localparam logic [1:0] MODE_ON      = 2'd0;
	localparam logic [1:0] MODE_OFF     = 2'd1;
	localparam logic [1:0] MODE_SUSPEND = 2'd2;
	localparam logic [1:0] MODE_BLINK   = 2'd3;

	localparam logic [1:0] BLINK_SHORT = 2'd0;
	localparam logic [1:0] BLINK_LONG  = 2'd1;

	localparam logic [2:0] REG_STEP_MIN    = 3'd0;
	localparam logic [2:0] REG_ON_HOLD     = 3'd1;
	localparam logic [2:0] REG_OFF_HOLD    = 3'd2;
	localparam logic [2:0] REG_BLINK_SHORT = 3'd3;
	localparam logic [2:0] REG_BLINK_LONG  = 3'd4;

	typedef struct packed {
		logic       operation;
		logic [1:0] mode;
		logic [1:0] blink_select;
	} in_t;

	typedef struct packed {
		logic [6:0] duty_percent;
		logic       pwm_enabled;
		logic       pin_released;
	} out_t;

endpackage

FILE: rtl/led_breathing_blink_controller.sv
// led_breathing_blink_controller: power led duty controller, top level
// input register, mode step logic, result register, apb register file
// depends on lbb_pkg

// One input transaction (set-mode or millisecond tick) is accepted per clock
// while in_ready is high and gives exactly one result transaction: the input
// register captures it, then the mode step runs against the stored state and
// loads the result register. While a result waits on
// out_ready the input register still takes one more transaction, after which
// in_ready drops until the result is taken. Registers are at byte offsets
// 0x00 step_min_ticks, 0x04 on_hold_ticks, 0x08 off_hold_ticks,
// 0x0C blink_short_ticks, 0x10 blink_long_ticks; a new value takes effect at
// the next step and does not alter a countdown already running. After reset
// the block behaves as if mode on had just been set.
module led_breathing_blink_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lbb_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output lbb_pkg::out_t out_data,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import lbb_pkg::*;

	// configuration registers
	logic [9:0]  step_min_q;
	logic [11:0] on_hold_q;
	logic [11:0] off_hold_q;
	logic [11:0] blink_short_q;
	logic [11:0] blink_long_q;

	// controller state
	logic [1:0]  mode_q;
	logic [6:0]  level_q;
	logic        ramp_up_q;
	logic        long_blink_q;
	logic [11:0] remaining_q;
	logic        wait_q;
	logic [6:0]  duty_q;
	logic        pwm_q;

	// pipeline
	logic valid_s1;
	in_t  data_s1;
	logic out_valid_q;
	out_t out_data_q;
	logic adv;

	// next state
	logic [1:0]  nxt_mode;
	logic [6:0]  nxt_level;
	logic        nxt_ramp;
	logic        nxt_long;
	logic [11:0] nxt_rem;
	logic        nxt_wait;
	logic [6:0]  nxt_duty;
	logic        nxt_pwm;
	logic        run;
	logic        ramp_dir;
	logic [2:0]  factor;
	logic [11:0] step_prod;
	logic [11:0] breathe_t;
	logic [7:0]  level_up;
	logic [6:0]  level_ramp;
	logic [2:0]  reg_idx;
	logic        cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_min_q    <= RST_STEP_MIN;
			on_hold_q     <= RST_ON_HOLD;
			off_hold_q    <= RST_OFF_HOLD;
			blink_short_q <= RST_BLINK_SHORT;
			blink_long_q  <= RST_BLINK_LONG;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_STEP_MIN:    step_min_q    <= pwdata[9:0];
				REG_ON_HOLD:     on_hold_q     <= pwdata[11:0];
				REG_OFF_HOLD:    off_hold_q    <= pwdata[11:0];
				REG_BLINK_SHORT: blink_short_q <= pwdata[11:0];
				REG_BLINK_LONG:  blink_long_q  <= pwdata[11:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_STEP_MIN:    prdata = {22'd0, step_min_q};
			REG_ON_HOLD:     prdata = {20'd0, on_hold_q};
			REG_OFF_HOLD:    prdata = {20'd0, off_hold_q};
			REG_BLINK_SHORT: prdata = {20'd0, blink_short_q};
			REG_BLINK_LONG:  prdata = {20'd0, blink_long_q};
			default:         prdata = 32'd0;
		endcase
	end

	// handshake and pipeline control
	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	// breathing step time: step_min * (1 + level/33), level at most 100; off_hold at level 0, on_hold at 100
	always_comb begin
		if (level_q >= 7'(3 * LEVEL_DIV)) begin
			factor = 3'd4;
		end else if (level_q >= 7'(2 * LEVEL_DIV)) begin
			factor = 3'd3;
		end else if (level_q >= LEVEL_DIV) begin
			factor = 3'd2;
		end else begin
			factor = 3'd1;
		end
		step_prod = 12'(step_min_q) * 12'(factor);
		if (level_q == 7'd0) begin
			ramp_dir  = 1'b1;
			breathe_t = off_hold_q;
		end else if (level_q >= LEVEL_MAX) begin
			ramp_dir  = 1'b0;
			breathe_t = on_hold_q;
		end else begin
			ramp_dir  = ramp_up_q;
			breathe_t = step_prod;
		end
		level_up = {1'b0, level_q} + 8'(STEP_PERCENT);
		if (ramp_dir) begin
			level_ramp = (level_up > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : level_up[6:0];
		end else begin
			level_ramp = (level_q < 7'(STEP_PERCENT)) ? 7'd0 : level_q - 7'(STEP_PERCENT);
		end
	end

	// mode step
	always_comb begin
		nxt_mode  = mode_q;
		nxt_level = level_q;
		nxt_ramp  = ramp_up_q;
		nxt_long  = long_blink_q;
		nxt_rem   = remaining_q;
		nxt_wait  = wait_q;
		nxt_duty  = duty_q;
		nxt_pwm   = pwm_q;
		run       = 1'b0;

		if (data_s1.operation == OP_SET_MODE) begin
			nxt_mode = data_s1.mode;
			if (data_s1.blink_select == BLINK_SHORT) begin
				nxt_long = 1'b0;
			end else if (data_s1.blink_select == BLINK_LONG) begin
				nxt_long = 1'b1;
			end
			run = 1'b1;
		end else if (!wait_q) begin
			if (remaining_q <= 12'd1) begin
				nxt_rem = 12'd0;
				run     = 1'b1;
			end else begin
				nxt_rem = remaining_q - 12'd1;
			end
		end

		if (run) begin
			unique case (nxt_mode)
				MODE_ON: begin
					nxt_pwm   = 1'b1;
					nxt_level = LEVEL_MAX;
					nxt_duty  = LEVEL_MAX;
					nxt_wait  = 1'b1;
				end
				MODE_OFF: begin
					nxt_pwm  = 1'b0;
					nxt_wait = 1'b1;
				end
				MODE_SUSPEND: begin
					nxt_pwm   = 1'b1;
					nxt_ramp  = ramp_dir;
					nxt_duty  = level_q;
					nxt_level = level_ramp;
					nxt_wait  = 1'b0;
					nxt_rem   = breathe_t;
				end
				default: begin
					nxt_pwm = 1'b1;
					if (level_q == 7'd0) begin
						nxt_level = LEVEL_MAX;
					end else if (level_q == LEVEL_MAX) begin
						nxt_level = 7'd0;
					end
					nxt_duty = nxt_level;
					nxt_wait = 1'b0;
					nxt_rem  = nxt_long ? blink_long_q : blink_short_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_ON;
			level_q      <= LEVEL_MAX;
			ramp_up_q    <= 1'b1;
			long_blink_q <= 1'b0;
			remaining_q  <= 12'd0;
			wait_q       <= 1'b1;
			duty_q       <= LEVEL_MAX;
			pwm_q        <= 1'b1;
		end else if (adv) begin
			mode_q       <= nxt_mode;
			level_q      <= nxt_level;
			ramp_up_q    <= nxt_ramp;
			long_blink_q <= nxt_long;
			remaining_q  <= nxt_rem;
			wait_q       <= nxt_wait;
			duty_q       <= nxt_duty;
			pwm_q        <= nxt_pwm;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q.duty_percent <= nxt_pwm ? nxt_duty : 7'd0;
			out_data_q.pwm_enabled  <= nxt_pwm;
			out_data_q.pin_released <= !nxt_pwm;
		end
	end

`ifndef SYNTHESIS
	a_pin_vs_pwm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.pwm_enabled != out_data.pin_released))
		else $error("pin_released does not mirror pwm_enabled");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.duty_percent <= LEVEL_MAX))
		else $error("duty above 100 percent");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LEVEL_MAX)
		else $error("stored level above 100");

	a_timer_mode: assert property (@(posedge clk) disable iff (!arst_n)
		!wait_q |-> (mode_q == MODE_SUSPEND || mode_q == MODE_BLINK))
		else $error("countdown armed outside suspend or blink");
`endif

endmodule

FILE: dv/led_breathing_blink_controller_tb.sv
`timescale 1ns / 100ps
// led_breathing_blink_controller_tb: self-checking testbench for the led duty controller
// drives mode/tick transactions and apb register writes and reads, predicts every result in place
// depends on lbb_pkg and rtl/led_breathing_blink_controller.sv

module led_breathing_blink_controller_tb;
	import lbb_pkg::*;

	localparam logic [1:0] BLINK_KEEP     = 2'd2;
	localparam logic [1:0] BLINK_KEEP_ALT = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_t         in_data;
	logic        out_valid;
	logic        out_ready;
	out_t        out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int   err_count = 0;
	int   idle_pct  = 0;
	out_t led_expect_q[$];

	// register shadow
	logic [9:0]  step_min;
	logic [11:0] on_hold;
	logic [11:0] off_hold;
	logic [11:0] blink_short;
	logic [11:0] blink_long;

	// controller state
	logic [1:0]  cur_mode;
	logic [6:0]  level;
	logic [6:0]  applied_duty;
	logic        ramp_up;
	logic        long_blink;
	logic        wait_forever;
	logic        pwm_on;
	logic [11:0] remaining;

	led_breathing_blink_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report_mismatch(string msg);
		$display("%0t ERROR: %s", $time, msg);
		err_count++;
	endtask

	function automatic void mode_step();
		int t;
		case (cur_mode)
			MODE_ON: begin
				pwm_on = 1'b1;
				level = LEVEL_MAX;
				applied_duty = LEVEL_MAX;
				wait_forever = 1'b1;
			end
			MODE_OFF: begin
				pwm_on = 1'b0;
				wait_forever = 1'b1;
			end
			MODE_SUSPEND: begin
				pwm_on = 1'b1;
				if (level == 7'd0) begin
					ramp_up = 1'b1;
					t = int'(off_hold);
				end else if (level >= LEVEL_MAX) begin
					ramp_up = 1'b0;
					t = int'(on_hold);
				end else begin
					t = int'(step_min) * (1 + int'(level) / int'(LEVEL_DIV));
				end
				applied_duty = level;
				if (ramp_up)
					level = (int'(level) + STEP_PERCENT > int'(LEVEL_MAX)) ? LEVEL_MAX :
						7'(int'(level) + STEP_PERCENT);
				else
					level = (int'(level) < STEP_PERCENT) ? 7'd0 : 7'(int'(level) - STEP_PERCENT);
				wait_forever = 1'b0;
				remaining = t[11:0];
			end
			default: begin
				pwm_on = 1'b1;
				if (level == 7'd0)
					level = LEVEL_MAX;
				else if (level == LEVEL_MAX)
					level = 7'd0;
				applied_duty = level;
				wait_forever = 1'b0;
				remaining = long_blink ? blink_long : blink_short;
			end
		endcase
	endfunction

	function automatic out_t predict_led_output(in_t d);
		out_t r;
		if (d.operation == OP_SET_MODE) begin
			cur_mode = d.mode;
			if (d.blink_select == BLINK_SHORT)
				long_blink = 1'b0;
			else if (d.blink_select == BLINK_LONG)
				long_blink = 1'b1;
			mode_step();
		end else if (!wait_forever) begin
			if (remaining <= 12'd1) begin
				remaining = 12'd0;
				mode_step();
			end else begin
				remaining = remaining - 12'd1;
			end
		end
		r.duty_percent = pwm_on ? applied_duty : 7'd0;
		r.pwm_enabled = pwm_on;
		r.pin_released = !pwm_on;
		return r;
	endfunction

	function automatic in_t led_event(logic op, logic [1:0] m, logic [1:0] sel);
		in_t d;
		d.operation = op;
		d.mode = m;
		d.blink_select = sel;
		return d;
	endfunction

	task automatic send_led_event(in_t d);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12) - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		led_expect_q.push_back(predict_led_output(d));
	endtask

	task automatic wait_led_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (led_expect_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_STEP_MIN:    step_min = v[9:0];
			REG_ON_HOLD:     on_hold = v[11:0];
			REG_OFF_HOLD:    off_hold = v[11:0];
			REG_BLINK_SHORT: blink_short = v[11:0];
			REG_BLINK_LONG:  blink_long = v[11:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_regs();
		logic [31:0] got;
		logic [31:0] want;
		for (int i = int'(REG_STEP_MIN); i <= int'(REG_BLINK_LONG); i++) begin
			@(negedge clk);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= {3'(i), 2'b00};
			@(negedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready) @(posedge clk);
			got = prdata;
			case (3'(i))
				REG_STEP_MIN:    want = {22'd0, step_min};
				REG_ON_HOLD:     want = {20'd0, on_hold};
				REG_OFF_HOLD:    want = {20'd0, off_hold};
				REG_BLINK_SHORT: want = {20'd0, blink_short};
				default:         want = {20'd0, blink_long};
			endcase
			if (got !== want)
				report_mismatch($sformatf("reg %0d read %0h, want %0h", i, got, want));
			@(negedge clk);
			psel <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	task automatic set_timing(int span);
		cfg_write(REG_STEP_MIN, ($urandom & ~32'h3FF) | 32'($urandom_range(1, span)));
		cfg_write(REG_ON_HOLD, ($urandom & ~32'hFFF) | 32'($urandom_range(1, 3 * span)));
		cfg_write(REG_OFF_HOLD, ($urandom & ~32'hFFF) | 32'($urandom_range(1, 3 * span)));
		cfg_write(REG_BLINK_SHORT, ($urandom & ~32'hFFF) | 32'($urandom_range(1, 2 * span)));
		cfg_write(REG_BLINK_LONG, ($urandom & ~32'hFFF) | 32'($urandom_range(1, 4 * span)));
	endtask

	// result checker
	always @(posedge clk) begin : check_led_result
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (led_expect_q.size() == 0) begin
				report_mismatch("result transaction with nothing expected");
			end else begin
				want = led_expect_q.pop_front();
				if (out_data.duty_percent !== want.duty_percent)
					report_mismatch($sformatf("duty_percent %0d, want %0d",
						out_data.duty_percent, want.duty_percent));
				if (out_data.pwm_enabled !== want.pwm_enabled)
					report_mismatch($sformatf("pwm_enabled %0b, want %0b",
						out_data.pwm_enabled, want.pwm_enabled));
				if (out_data.pin_released !== want.pin_released)
					report_mismatch($sformatf("pin_released %0b, want %0b",
						out_data.pin_released, want.pin_released));
			end
		end
	end

	// receiver stalls
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic test_modes_after_reset();
		send_led_event(led_event(OP_TICK, MODE_BLINK, BLINK_KEEP_ALT));
		send_led_event(led_event(OP_SET_MODE, MODE_OFF, BLINK_SHORT));
		send_led_event(led_event(OP_TICK, MODE_SUSPEND, BLINK_LONG));
		send_led_event(led_event(OP_SET_MODE, MODE_BLINK, BLINK_KEEP));
		send_led_event(led_event(OP_SET_MODE, MODE_BLINK, BLINK_LONG));
		send_led_event(led_event(OP_SET_MODE, MODE_SUSPEND, BLINK_KEEP));
		send_led_event(led_event(OP_SET_MODE, MODE_ON, BLINK_KEEP_ALT));
	endtask

	task automatic test_zero_timeout();
		wait_led_drain();
		for (int i = int'(REG_STEP_MIN); i <= int'(REG_BLINK_LONG); i++)
			cfg_write(3'(i), 32'hFFFF_F000);
		check_regs();
		send_led_event(led_event(OP_SET_MODE, MODE_SUSPEND, BLINK_SHORT));
		repeat (3) send_led_event(led_event(OP_TICK, MODE_ON, BLINK_SHORT));
		send_led_event(led_event(OP_SET_MODE, MODE_BLINK, BLINK_SHORT));
		repeat (2) send_led_event(led_event(OP_TICK, MODE_OFF, BLINK_LONG));
	endtask

	task automatic test_register_extremes();
		wait_led_drain();
		cfg_write(REG_STEP_MIN, ($urandom & ~32'h3FF) | 32'h3FF);
		cfg_write(REG_ON_HOLD, ($urandom & ~32'hFFF) | 32'hFFF);
		cfg_write(REG_OFF_HOLD, ($urandom & ~32'hFFF) | 32'hFFF);
		cfg_write(REG_BLINK_SHORT, ($urandom & ~32'hFFF) | 32'hFFF);
		cfg_write(REG_BLINK_LONG, ($urandom & ~32'hFFF) | 32'hFFF);
		check_regs();
		send_led_event(led_event(OP_SET_MODE, MODE_SUSPEND, BLINK_KEEP));
		send_led_event(led_event(OP_TICK, MODE_SUSPEND, BLINK_KEEP));
		send_led_event(led_event(OP_SET_MODE, MODE_BLINK, BLINK_LONG));
		send_led_event(led_event(OP_TICK, MODE_BLINK, BLINK_LONG));
	endtask

	task automatic test_register_change();
		wait_led_drain();
		cfg_write(REG_BLINK_SHORT, 32'd3);
		send_led_event(led_event(OP_SET_MODE, MODE_BLINK, BLINK_SHORT));
		wait_led_drain();
		cfg_write(REG_BLINK_SHORT, 32'd50);
		repeat (3) send_led_event(led_event(OP_TICK, MODE_BLINK, BLINK_SHORT));
	endtask

	task automatic test_unknown_register();
		wait_led_drain();
		for (int i = int'(REG_BLINK_LONG) + 1; i < 8; i++)
			cfg_write(3'(i), $urandom);
		check_regs();
	endtask

	task automatic test_random_events(int count, int pct, int span);
		in_t d;
		int  done;
		int  pick;
		done = 0;
		idle_pct = 0;
		wait_led_drain();
		set_timing(span);
		idle_pct = pct;
		while (done < count) begin
			d.operation = ($urandom_range(0, 99) < 6) ? OP_SET_MODE : OP_TICK;
			d.blink_select = 2'($urandom_range(0, 3));
			if (d.operation == OP_SET_MODE) begin
				pick = $urandom_range(0, 9);
				d.mode = (pick < 1) ? MODE_ON : (pick < 2) ? MODE_OFF :
					(pick < 6) ? MODE_SUSPEND : MODE_BLINK;
			end else begin
				d.mode = 2'($urandom_range(0, 3));
			end
			if (d.operation == OP_SET_MODE || !wait_forever)
				done++;
			send_led_event(d);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		step_min = RST_STEP_MIN;
		on_hold = RST_ON_HOLD;
		off_hold = RST_OFF_HOLD;
		blink_short = RST_BLINK_SHORT;
		blink_long = RST_BLINK_LONG;
		cur_mode = MODE_ON;
		level = LEVEL_MAX;
		applied_duty = LEVEL_MAX;
		ramp_up = 1'b1;
		long_blink = 1'b0;
		wait_forever = 1'b1;
		pwm_on = 1'b1;
		remaining = 12'd0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_modes_after_reset();
		test_zero_timeout();
		test_register_extremes();
		test_register_change();
		test_unknown_register();
		test_random_events(150, 15, 2);
		test_random_events(150, 35, 6);
		test_random_events(150, 5, 1);
		test_random_events(150, 0, 2);

		wait_led_drain();
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
